### hdl/assert_macros.svh
// Assertion macros used by the dispatcher RTL.
// Expects aclk and aresetn in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/apd_pkg.sv
// Package for the accelerator pool dispatcher: widths, codes, types.
// No dependencies.
package apd_pkg;

    localparam int NUM_UNITS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int STALL_DEPTH_DEF = 64;
    localparam int NUM_WORKERS_DEF = 16;

    localparam int TAG_W      = 8;
    localparam int UNIT_W     = 3;
    localparam int KIND_W     = 3;
    localparam int CNT_W      = 7;
    localparam int LIVE_W     = 4;
    localparam int WID_W      = 8;
    localparam int ROUTE_W    = 48;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 48;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED   = 3'd0,
        KIND_DISPATCHED = 3'd1,
        KIND_FORWARDED  = 3'd2,
        KIND_STALLED    = 3'd3,
        KIND_DROPPED    = 3'd4
    } kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_UNITS = 2'd1,
        CFG_LIMIT = 2'd2,
        CFG_ROUTE = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROMOTE,
        ST_SELECT,
        ST_EMIT_FIRST,
        ST_EMIT_DISP,
        ST_EMIT_FWD
    } back_state_t;

    typedef struct packed {
        logic              per_unit_mode;
        logic [LIVE_W-1:0] live_units;
        logic [CNT_W-1:0]  admit_limit;
    } cfg_t;

    typedef struct packed {
        logic              is_done;
        logic [TAG_W-1:0]  tag;
        logic [UNIT_W-1:0] q;
        logic [UNIT_W-1:0] done_unit;
        logic              done_ok;
    } job_t;

endpackage

### hdl/accelerator_pool_dispatcher.sv
// Accelerator pool dispatcher: configuration registers, front end and back end.
// Depends on apd_pkg, apd_front, apd_back.
//
// Usage:
//   s_ channel carries job requests (s_tuser 0) and unit completions (s_tuser 1).
//   m_ channel carries results: accepted, dispatched, forwarded, stalled,
//   dropped, kind in m_tuser; m_tlast marks the last result of an input item.
//   Each item yields one to three results.
//   cfg_we/cfg_addr/cfg_wdata write mode, unit count, admission limit and the
//   worker route table; write only while the block is idle.
//   Sequence: the back end performs admission, then promotes a stall queue
//   head when one is due (queue memory read), then does the busy-bit priority
//   encode and dispatch, then passes through each output stage in turn; it
//   takes a new item only when it is back in idle.
//   A two-entry queue between front and back keeps s_tready high while the
//   back end works, until two items wait.
//   Reset (aresetn low, synchronous) frees all units, empties all queues,
//   zeroes admission counts and restores register defaults.
//   When m_tready is low the result is held and the back end waits; the
//   front queue then fills and s_tready drops.
module accelerator_pool_dispatcher #(
    parameter int NUM_UNITS   = apd_pkg::NUM_UNITS_DEF,
    parameter int QUEUE_DEPTH = apd_pkg::QUEUE_DEPTH_DEF,
    parameter int STALL_DEPTH = apd_pkg::STALL_DEPTH_DEF,
    parameter int NUM_WORKERS = apd_pkg::NUM_WORKERS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // job_tag[7:0], has_worker[8], worker_id[16:9], done_unit[19:17], zero pad
    input  logic [apd_pkg::S_DATA_W-1:0]   s_tdata,
    // req_type
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_tag[7:0], out_unit[10:8], zero pad
    output logic [apd_pkg::M_DATA_W-1:0]   m_tdata,
    // kind
    output logic [apd_pkg::KIND_W-1:0]     m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [apd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [apd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import apd_pkg::*;

    logic               mode_reg;
    logic [LIVE_W-1:0]  units_reg;
    logic [CNT_W-1:0]   limit_reg;
    logic [ROUTE_W-1:0] route_reg;
    cfg_t               cfg;
    logic               job_valid;
    logic               job_pop;
    job_t               job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            units_reg <= LIVE_W'(8);
            limit_reg <= CNT_W'(64);
            route_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_MODE:  mode_reg  <= cfg_wdata[0];
                CFG_UNITS: units_reg <= cfg_wdata[LIVE_W-1:0];
                CFG_LIMIT: limit_reg <= cfg_wdata[CNT_W-1:0];
                CFG_ROUTE: route_reg <= cfg_wdata[ROUTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.per_unit_mode = mode_reg;
        cfg.admit_limit   = limit_reg;
        if (units_reg == '0) begin
            cfg.live_units = LIVE_W'(1);
        end else if (units_reg > LIVE_W'(NUM_UNITS)) begin
            cfg.live_units = LIVE_W'(NUM_UNITS);
        end else begin
            cfg.live_units = units_reg;
        end
    end

    apd_front #(
        .NUM_WORKERS (NUM_WORKERS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg       (cfg),
        .route     (route_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    apd_back #(
        .NUM_UNITS   (NUM_UNITS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STALL_DEPTH (STALL_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

### hdl/apd_front.sv
// Front end: accepts items, resolves the target queue, holds them in a
// two-entry queue for the back end. Depends on apd_pkg.
module apd_front #(
    parameter int NUM_WORKERS = apd_pkg::NUM_WORKERS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // job_tag[7:0], has_worker[8], worker_id[16:9], done_unit[19:17], zero pad
    input  logic [apd_pkg::S_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic                          s_tuser,
    input  apd_pkg::cfg_t                 cfg,
    input  logic [apd_pkg::ROUTE_W-1:0]   route,
    output logic                          job_valid,
    output apd_pkg::job_t                 job,
    input  logic                          job_pop
);
    import apd_pkg::*;

    logic [TAG_W-1:0]  in_tag;
    logic              in_hw;
    logic [WID_W-1:0]  in_wid;
    logic [UNIT_W-1:0] in_done;
    logic [UNIT_W-1:0] entry;
    logic              hit;
    job_t              cls;

    job_t              fifo_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push;

    assign in_tag  = s_tdata[7:0];
    assign in_hw   = s_tdata[8];
    assign in_wid  = s_tdata[16:9];
    assign in_done = s_tdata[19:17];

    always_comb begin
        entry = '0;
        for (int w = 0; w < NUM_WORKERS; w++) begin
            if (in_wid == WID_W'(w)) begin
                entry = route[UNIT_W*w +: UNIT_W];
            end
        end
        hit = in_hw && (in_wid < WID_W'(NUM_WORKERS));
        cls.is_done   = s_tuser;
        cls.tag       = in_tag;
        cls.done_unit = in_done;
        cls.done_ok   = {1'b0, in_done} < cfg.live_units;
        if (s_tuser) begin
            cls.q = cfg.per_unit_mode ? in_done : '0;
        end else if (cfg.per_unit_mode && hit && ({1'b0, entry} < cfg.live_units)) begin
            cls.q = entry;
        end else begin
            cls.q = '0;
        end
    end

    assign s_tready  = (count_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign job_valid = (count_reg != 2'd0);
    assign job       = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = job_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(job_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

### hdl/apd_back.sv
// Back end: admission counts, admitted and stall queues in memory, busy
// bits, dispatch and result output register. Depends on apd_pkg.
`include "assert_macros.svh"

module apd_back #(
    parameter int NUM_UNITS   = apd_pkg::NUM_UNITS_DEF,
    parameter int QUEUE_DEPTH = apd_pkg::QUEUE_DEPTH_DEF,
    parameter int STALL_DEPTH = apd_pkg::STALL_DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  apd_pkg::cfg_t                cfg,
    input  logic                         job_valid,
    input  apd_pkg::job_t                job,
    output logic                         job_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // job tag[7:0], unit[10:8], zero pad
    output logic [apd_pkg::M_DATA_W-1:0] m_tdata,
    // kind
    output logic [apd_pkg::KIND_W-1:0]   m_tuser,
    output logic                         m_tlast
);
    import apd_pkg::*;

    localparam int QW   = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
    localparam int AP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int AL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int AS_W = AL_W + 1;
    localparam int AA_W = (NUM_UNITS * QUEUE_DEPTH > 1) ? $clog2(NUM_UNITS * QUEUE_DEPTH) : 1;
    localparam int SP_W = (STALL_DEPTH > 1) ? $clog2(STALL_DEPTH) : 1;
    localparam int SL_W = $clog2(STALL_DEPTH + 1);
    localparam int SS_W = SL_W + 1;
    localparam int SA_W = (NUM_UNITS * STALL_DEPTH > 1) ? $clog2(NUM_UNITS * STALL_DEPTH) : 1;

    back_state_t       state_reg, state_next;
    job_t              cur_reg;
    logic [NUM_UNITS-1:0] busy_reg;
    logic [CNT_W-1:0]  cnt_reg    [NUM_UNITS];
    logic [AP_W-1:0]   aq_head_reg [NUM_UNITS];
    logic [AL_W-1:0]   aq_len_reg  [NUM_UNITS];
    logic [SP_W-1:0]   sq_head_reg [NUM_UNITS];
    logic [SL_W-1:0]   sq_len_reg  [NUM_UNITS];
    logic [TAG_W-1:0]  aq_mem [NUM_UNITS*QUEUE_DEPTH];
    logic [TAG_W-1:0]  sq_mem [NUM_UNITS*STALL_DEPTH];
    logic [TAG_W-1:0]  aq_rd_reg, sq_rd_reg;

    logic              res1_valid_reg, res1_valid_next;
    kind_t             res1_kind_reg, res1_kind_next;
    logic [TAG_W-1:0]  res1_tag_reg, res1_tag_next;
    logic              res1_load;
    logic              disp_reg;
    logic [QW-1:0]     disp_unit_reg;

    logic              m_valid_reg;
    kind_t             m_kind_reg;
    logic [TAG_W-1:0]  m_tag_reg;
    logic [UNIT_W-1:0] m_unit_reg;
    logic              m_last_reg;

    logic [QW-1:0]     jq, jd, cur_q, dq, disp_idx;
    logic              cnt_inc, cnt_dec, aq_push, aq_pop, sq_push, sq_pop;
    logic              busy_clr, busy_set, disp_found, sel_cycle;
    logic [QW-1:0]     aq_push_q;
    logic [TAG_W-1:0]  aq_push_data;
    logic [AS_W-1:0]   aq_sum;
    logic [AP_W-1:0]   aq_tail;
    logic [SS_W-1:0]   sq_sum;
    logic [SP_W-1:0]   sq_tail;
    logic [NUM_UNITS-1:0] cand;
    logic              out_free, out_load, out_last;
    kind_t             out_kind;
    logic [TAG_W-1:0]  out_tag;
    logic [UNIT_W-1:0] out_unit;

    assign jq    = job.q[QW-1:0];
    assign jd    = job.done_unit[QW-1:0];
    assign cur_q = cur_reg.q[QW-1:0];
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        cand = '0;
        for (int i = 0; i < NUM_UNITS; i++) begin
            if (cfg.per_unit_mode) begin
                cand[i] = (aq_len_reg[i] != '0) && !busy_reg[i] &&
                          (LIVE_W'(i) < cfg.live_units);
            end else begin
                cand[i] = (aq_len_reg[0] != '0) && !busy_reg[i] &&
                          (LIVE_W'(i) < cfg.live_units);
            end
        end
        disp_found = |cand;
        disp_idx   = '0;
        for (int i = NUM_UNITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                disp_idx = QW'(i);
            end
        end
        dq = cfg.per_unit_mode ? disp_idx : '0;
    end

    always_comb begin
        aq_push_q    = (state_reg == ST_PROMOTE) ? cur_q : jq;
        aq_push_data = (state_reg == ST_PROMOTE) ? sq_rd_reg : job.tag;
        aq_sum  = AS_W'(aq_head_reg[aq_push_q]) + AS_W'(aq_len_reg[aq_push_q]);
        aq_tail = (aq_sum >= AS_W'(QUEUE_DEPTH)) ? AP_W'(aq_sum - AS_W'(QUEUE_DEPTH))
                                                 : AP_W'(aq_sum);
        sq_sum  = SS_W'(sq_head_reg[jq]) + SS_W'(sq_len_reg[jq]);
        sq_tail = (sq_sum >= SS_W'(STALL_DEPTH)) ? SP_W'(sq_sum - SS_W'(STALL_DEPTH))
                                                 : SP_W'(sq_sum);
    end

    always_comb begin
        state_next      = state_reg;
        job_pop         = 1'b0;
        cnt_inc         = 1'b0;
        cnt_dec         = 1'b0;
        aq_push         = 1'b0;
        aq_pop          = 1'b0;
        sq_push         = 1'b0;
        sq_pop          = 1'b0;
        busy_clr        = 1'b0;
        busy_set        = 1'b0;
        sel_cycle       = 1'b0;
        res1_load       = 1'b0;
        res1_valid_next = 1'b0;
        res1_kind_next  = KIND_ACCEPTED;
        res1_tag_next   = job.tag;
        out_load        = 1'b0;
        out_kind        = KIND_ACCEPTED;
        out_tag         = res1_tag_reg;
        out_unit        = cur_reg.q;
        out_last        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    res1_load  = 1'b1;
                    state_next = ST_SELECT;
                    if (!job.is_done) begin
                        res1_valid_next = 1'b1;
                        if ((cnt_reg[jq] < cfg.admit_limit) &&
                            (aq_len_reg[jq] < AL_W'(QUEUE_DEPTH))) begin
                            cnt_inc        = 1'b1;
                            aq_push        = 1'b1;
                            res1_kind_next = KIND_ACCEPTED;
                        end else if (sq_len_reg[jq] < SL_W'(STALL_DEPTH)) begin
                            sq_push        = 1'b1;
                            res1_kind_next = KIND_STALLED;
                        end else begin
                            res1_kind_next = KIND_DROPPED;
                        end
                    end else if (job.done_ok) begin
                        busy_clr = 1'b1;
                        if ((sq_len_reg[jq] != '0) &&
                            (aq_len_reg[jq] < AL_W'(QUEUE_DEPTH))) begin
                            sq_pop     = 1'b1;
                            state_next = ST_PROMOTE;
                        end else if (cnt_reg[jq] != '0) begin
                            cnt_dec = 1'b1;
                        end
                    end
                end
            end
            ST_PROMOTE: begin
                aq_push         = 1'b1;
                res1_load       = 1'b1;
                res1_valid_next = 1'b1;
                res1_kind_next  = KIND_ACCEPTED;
                res1_tag_next   = sq_rd_reg;
                state_next      = ST_SELECT;
            end
            ST_SELECT: begin
                sel_cycle = 1'b1;
                if (disp_found) begin
                    busy_set = 1'b1;
                    aq_pop   = 1'b1;
                end
                state_next = ST_EMIT_FIRST;
            end
            ST_EMIT_FIRST: begin
                if (!res1_valid_reg) begin
                    state_next = ST_EMIT_DISP;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = res1_kind_reg;
                    out_last   = !disp_reg && !cur_reg.is_done;
                    state_next = ST_EMIT_DISP;
                end
            end
            ST_EMIT_DISP: begin
                if (!disp_reg) begin
                    state_next = ST_EMIT_FWD;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = KIND_DISPATCHED;
                    out_tag    = aq_rd_reg;
                    out_unit   = UNIT_W'(disp_unit_reg);
                    out_last   = !cur_reg.is_done;
                    state_next = ST_EMIT_FWD;
                end
            end
            ST_EMIT_FWD: begin
                if (!cur_reg.is_done) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = KIND_FORWARDED;
                    out_tag    = cur_reg.tag;
                    out_unit   = cur_reg.done_unit;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            busy_reg       <= '0;
            res1_valid_reg <= 1'b0;
            disp_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_UNITS; i++) begin
                cnt_reg[i]     <= '0;
                aq_head_reg[i] <= '0;
                aq_len_reg[i]  <= '0;
                sq_head_reg[i] <= '0;
                sq_len_reg[i]  <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (res1_load) begin
                res1_valid_reg <= res1_valid_next;
            end
            if (sel_cycle) begin
                disp_reg <= disp_found;
            end
            if (cnt_inc) begin
                cnt_reg[jq] <= cnt_reg[jq] + 1'b1;
            end
            if (cnt_dec) begin
                cnt_reg[jq] <= cnt_reg[jq] - 1'b1;
            end
            if (busy_clr) begin
                busy_reg[jd] <= 1'b0;
            end
            if (busy_set) begin
                busy_reg[disp_idx] <= 1'b1;
            end
            if (aq_push) begin
                aq_len_reg[aq_push_q] <= aq_len_reg[aq_push_q] + 1'b1;
            end
            if (aq_pop) begin
                aq_len_reg[dq]  <= aq_len_reg[dq] - 1'b1;
                aq_head_reg[dq] <= (aq_head_reg[dq] == AP_W'(QUEUE_DEPTH - 1)) ?
                                   '0 : aq_head_reg[dq] + 1'b1;
            end
            if (sq_push) begin
                sq_len_reg[jq] <= sq_len_reg[jq] + 1'b1;
            end
            if (sq_pop) begin
                sq_len_reg[jq]  <= sq_len_reg[jq] - 1'b1;
                sq_head_reg[jq] <= (sq_head_reg[jq] == SP_W'(STALL_DEPTH - 1)) ?
                                   '0 : sq_head_reg[jq] + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            cur_reg <= job;
        end
        if (res1_load) begin
            res1_kind_reg <= res1_kind_next;
            res1_tag_reg  <= res1_tag_next;
        end
        if (sel_cycle) begin
            disp_unit_reg <= disp_idx;
        end
        if (out_load) begin
            m_kind_reg <= out_kind;
            m_tag_reg  <= out_tag;
            m_unit_reg <= out_unit;
            m_last_reg <= out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (aq_push) begin
            aq_mem[AA_W'(aq_push_q) * AA_W'(QUEUE_DEPTH) + AA_W'(aq_tail)] <= aq_push_data;
        end
        if (aq_pop) begin
            aq_rd_reg <= aq_mem[AA_W'(dq) * AA_W'(QUEUE_DEPTH) + AA_W'(aq_head_reg[dq])];
        end
    end

    always_ff @(posedge aclk) begin
        if (sq_push) begin
            sq_mem[SA_W'(jq) * SA_W'(STALL_DEPTH) + SA_W'(sq_tail)] <= job.tag;
        end
        if (sq_pop) begin
            sq_rd_reg <= sq_mem[SA_W'(jq) * SA_W'(STALL_DEPTH) + SA_W'(sq_head_reg[jq])];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - TAG_W - UNIT_W)'(0), m_unit_reg, m_tag_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    `ASSERT_ALWAYS(a_aq_len_bound, aq_len_reg[0] <= AL_W'(QUEUE_DEPTH), "admitted queue overfilled")
    `ASSERT_NEXT(a_disp_busy, (state_reg == ST_SELECT) && disp_found, busy_reg[disp_unit_reg] && disp_reg, "dispatch did not mark unit busy")
    `ASSERT_ALWAYS(a_emit_busy, !((state_reg == ST_EMIT_DISP) && disp_reg) || busy_reg[disp_unit_reg], "dispatched unit not busy at emit")

endmodule
